// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the rotator RTL.
// Defining NO_ASSERTIONS turns every check into an empty statement.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checks a property on every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

// ===== rtl/ir90_pkg.sv =====
// Shared types and constants of the 90-degree image rotator.
// Used by ir90_front, ir90_back and image_rotate_90_top; depends on nothing.
`timescale 1ns / 1ps

package ir90_pkg;

   // Default largest image side, in pixels.
   localparam int DEFAULT_MAX_SIDE = 256;

   // Widths fixed by the channel formats.
   localparam int PIXEL_W    = 32;
   localparam int RSP_DATA_W = 48;
   localparam int CFG_W      = 9;
   localparam int CSR_IDX_W  = 2;

   // Depth of the request queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_EN      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROTATE_CCW    = 2'd3;

   // Configuration reset values.
   localparam logic [CFG_W-1:0] CFG_SIDE_RESET = 9'd256;

   // Kind of request.
   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_FETCH = 1'b1
   } item_op_type;

   // One classified request as held in the queue.
   typedef struct packed {
      item_op_type        op;
      logic [PIXEL_W-1:0] pixel;
   } queue_item_type;

   // Sequencer of the back part.
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_ADDR,
      BK_READ,
      BK_OUT
   } back_state_type;

endpackage

// ===== rtl/ir90_front.sv =====
// Front part of the rotator: accepts requests, classifies them as load or fetch
// and holds them in a short queue for the back part. Depends on ir90_pkg.
`timescale 1ns / 1ps

module ir90_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [ir90_pkg::PIXEL_W-1:0]  req_tdata,   // red, green, blue, alpha
   input  logic                          req_tuser,   // mode
   output logic                          q_valid,
   output ir90_pkg::queue_item_type      q_item,
   input  logic                          q_pop
);

   localparam int DEPTH = ir90_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ir90_pkg::queue_item_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;
   ir90_pkg::queue_item_type new_item;

   // Classify the incoming request.
   always_comb begin
      new_item.op    = req_tuser ? ir90_pkg::OP_FETCH : ir90_pkg::OP_LOAD;
      new_item.pixel = req_tdata;
   end

   assign req_tready = (count_ff != CNT_W'(DEPTH));
   assign push       = req_tvalid & req_tready;
   assign q_valid    = (count_ff != '0);
   assign pop        = q_pop & q_valid;
   assign q_item     = entry_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage; payload only, no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// ===== rtl/ir90_back.sv =====
// Back part of the rotator: frame store, load and fetch counters, address
// sequencer and the result register. Depends on ir90_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ir90_back #(
   parameter int MAX_SIDE = ir90_pkg::DEFAULT_MAX_SIDE
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_valid,
   input  ir90_pkg::queue_item_type         q_item,
   output logic                             q_pop,
   input  logic [$clog2(MAX_SIDE+1)-1:0]    side_w,
   input  logic [$clog2(MAX_SIDE+1)-1:0]    side_h,
   input  logic [$clog2(MAX_SIDE*MAX_SIDE+1)-1:0] total,
   input  logic                             alpha_en,
   input  logic                             rotate_ccw,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [ir90_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tlast
);

   localparam int SIDE_W    = $clog2(MAX_SIDE + 1);
   localparam int CNT_W     = $clog2(MAX_SIDE);
   localparam int MEM_DEPTH = MAX_SIDE * MAX_SIDE;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int LOAD_W    = $clog2(MEM_DEPTH + 1);
   localparam int PROD_W    = CNT_W + SIDE_W;

   ir90_pkg::back_state_type state_ff, state_in;

   // Frame store.
   logic [ir90_pkg::PIXEL_W-1:0] frame_mem [MEM_DEPTH];
   logic [ir90_pkg::PIXEL_W-1:0] rd_data_ff;
   logic                         mem_we;
   logic                         mem_re;

   // Control state.
   logic [LOAD_W-1:0] load_count_ff, load_count_in;
   logic [CNT_W-1:0]  out_row_ff, out_row_in;
   logic [CNT_W-1:0]  out_col_ff, out_col_in;
   logic              image_ready_ff, image_ready_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Per-fetch working registers.
   logic [CNT_W-1:0]  srow_ff, srow_in;
   logic [CNT_W-1:0]  scol_ff, scol_in;
   logic [CNT_W-1:0]  dest_row_ff, dest_col_ff;
   logic              last_ff;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              fetch_go;

   // Result register.
   logic [ir90_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                            rsp_last_ff;
   logic                            load_out;

   // Shared decode.
   logic              ready_eff;
   logic              is_fetch;
   logic [CNT_W-1:0]  row_lim, col_lim;
   logic [CNT_W-1:0]  r_clamp, c_clamp;
   logic              last_now;
   logic [LOAD_W:0]   load_next;
   logic [PROD_W-1:0] addr_prod;
   logic [7:0]        alpha_sel;

   assign ready_eff = image_ready_ff | (load_count_ff >= total);
   assign is_fetch  = (q_item.op == ir90_pkg::OP_FETCH);
   assign row_lim   = CNT_W'(side_w - 1'b1);
   assign col_lim   = CNT_W'(side_h - 1'b1);
   assign r_clamp   = (out_row_ff < row_lim) ? out_row_ff : row_lim;
   assign c_clamp   = (out_col_ff < col_lim) ? out_col_ff : col_lim;
   assign last_now  = (out_row_ff >= row_lim) && (out_col_ff >= col_lim);
   assign load_next = {1'b0, load_count_ff} + 1'b1;
   assign addr_prod = PROD_W'(srow_ff) * PROD_W'(side_w) + PROD_W'(scol_ff);
   assign alpha_sel = alpha_en ? rd_data_ff[31:24] : 8'd0;

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ir90_pkg::BK_IDLE: begin
            if (q_valid && is_fetch && ready_eff) begin
               state_in = ir90_pkg::BK_ADDR;
            end
         end
         ir90_pkg::BK_ADDR: state_in = ir90_pkg::BK_READ;
         ir90_pkg::BK_READ: state_in = ir90_pkg::BK_OUT;
         ir90_pkg::BK_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ir90_pkg::BK_IDLE;
            end
         end
         default: state_in = ir90_pkg::BK_IDLE;
      endcase
   end

   // Sequencer outputs and counter updates.
   always_comb begin
      q_pop          = 1'b0;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      fetch_go       = 1'b0;
      load_out       = 1'b0;
      load_count_in  = load_count_ff;
      out_row_in     = out_row_ff;
      out_col_in     = out_col_ff;
      image_ready_in = image_ready_ff;
      srow_in        = srow_ff;
      scol_in        = scol_ff;
      addr_in        = addr_ff;
      case (state_ff)
         ir90_pkg::BK_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (!is_fetch) begin
                  // A load is stored only while the image is incomplete.
                  if (!ready_eff) begin
                     mem_we         = 1'b1;
                     load_count_in  = load_next[LOAD_W-1:0];
                     image_ready_in = (load_next >= {1'b0, total});
                  end else begin
                     image_ready_in = 1'b1;
                  end
               end else if (ready_eff) begin
                  fetch_go = 1'b1;
                  if (rotate_ccw) begin
                     srow_in = c_clamp;
                     scol_in = row_lim - r_clamp;
                  end else begin
                     srow_in = col_lim - c_clamp;
                     scol_in = r_clamp;
                  end
                  // Step through the destination in raster order.
                  if (last_now) begin
                     load_count_in  = '0;
                     out_row_in     = '0;
                     out_col_in     = '0;
                     image_ready_in = 1'b0;
                  end else if (out_col_ff >= col_lim) begin
                     out_col_in     = '0;
                     out_row_in     = out_row_ff + 1'b1;
                     image_ready_in = 1'b1;
                  end else begin
                     out_col_in     = out_col_ff + 1'b1;
                     image_ready_in = 1'b1;
                  end
               end
            end
         end
         ir90_pkg::BK_ADDR: addr_in = addr_prod[ADDR_W-1:0];
         ir90_pkg::BK_READ: mem_re = 1'b1;
         ir90_pkg::BK_OUT:  load_out = !rsp_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   // Result register: loads a new pixel, or drains when the receiver takes it.
   always_comb begin
      rsp_data_in = {8'(dest_col_ff), 8'(dest_row_ff), alpha_sel,
                     rd_data_ff[23:16], rd_data_ff[15:8], rd_data_ff[7:0]};
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ir90_pkg::BK_IDLE;
         load_count_ff  <= '0;
         out_row_ff     <= '0;
         out_col_ff     <= '0;
         image_ready_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         load_count_ff  <= load_count_in;
         out_row_ff     <= out_row_in;
         out_col_ff     <= out_col_in;
         image_ready_ff <= image_ready_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      srow_ff <= srow_in;
      scol_ff <= scol_in;
      addr_ff <= addr_in;
      if (fetch_go) begin
         dest_row_ff <= out_row_ff;
         dest_col_ff <= out_col_ff;
         last_ff     <= last_now;
      end
      if (load_out) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= last_ff;
      end
   end

   // Frame store: one write or one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[load_count_ff[ADDR_W-1:0]] <= q_item.pixel;
      end
      if (mem_re) begin
         rd_data_ff <= frame_mem[addr_ff];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // A fetch runs address, read and output steps in a fixed order.
   `ASSERT_PROP(a_fetch_order, clock, reset, (state_ff == ir90_pkg::BK_ADDR) |=> (state_ff == ir90_pkg::BK_READ) ##1 (state_ff == ir90_pkg::BK_OUT), "fetch sequence broken")

   // The last pixel of an image empties the block.
   `ASSERT_PROP(a_last_restarts, clock, reset, (fetch_go && last_now) |=> (load_count_ff == '0) && !image_ready_ff && (out_row_ff == '0) && (out_col_ff == '0), "last pixel did not restart")

   // A result waiting on the receiver keeps the sequencer parked.
   `ASSERT_PROP(a_out_stall, clock, reset, (state_ff == ir90_pkg::BK_OUT && rsp_valid_ff && !rsp_tready) |=> (state_ff == ir90_pkg::BK_OUT), "sequencer left while result stalled")

   // A new result only appears after the output step.
   `ASSERT_PROP(a_rsp_source, clock, reset, $rose(rsp_valid_ff) |-> ($past(state_ff) == ir90_pkg::BK_OUT), "result without fetch")

endmodule

// ===== rtl/image_rotate_90_top.sv =====
// Top level of the 90-degree image rotator: configuration registers, side
// clamping and frame size. Depends on ir90_pkg, ir90_front and ir90_back.
`timescale 1ns / 1ps

// Usage
// The request channel carries either a source pixel to load (tuser low) or a
// fetch of the next rotated pixel (tuser high). Loads fill the frame store in
// source raster order until width times height pixels are held; further loads
// are dropped. Each fetch on a complete image returns one destination pixel on
// the response channel with its row and column, tlast marking the final one;
// a fetch on an incomplete image returns nothing. After the final pixel the
// block starts over and waits for a new image.
// Requests enter a two-entry queue. Loads retire at one per cycle while the
// back part is idle; a fetch holds the back part through its sequencer step,
// address multiply, frame store read and result register, and longer while
// the receiver stalls.
// A stalled receiver holds the result register; the queue keeps taking
// requests until it is full. Reset empties the queue and the result register,
// clears the counters and restores the registers (256 by 256, no alpha,
// counter-clockwise). The frame store is not cleared.
// Configuration writes are taken in any cycle and must come while idle.

module image_rotate_90_top #(
   parameter int MAX_SIDE = ir90_pkg::DEFAULT_MAX_SIDE
) (
   input  logic                             clock,
   input  logic                             reset,
   // Request channel.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [ir90_pkg::PIXEL_W-1:0]     req_tdata,   // red_in, green_in, blue_in, alpha_in
   input  logic                             req_tuser,   // mode
   // Response channel.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [ir90_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // red_out, green_out, blue_out,
                                                         // alpha_out, dest_row, dest_col
   output logic                             rsp_tlast,   // last_pixel
   // Configuration write channel.
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ir90_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ir90_pkg::CFG_W-1:0]       csr_data
);

   localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
   localparam int LOAD_W  = $clog2(MAX_SIDE * MAX_SIDE + 1);
   localparam int CMP_W   = (SIDE_W > ir90_pkg::CFG_W) ? SIDE_W : ir90_pkg::CFG_W;
   localparam int AREA_W  = 2 * SIDE_W;

   logic [ir90_pkg::CFG_W-1:0] width_ff, width_in;
   logic [ir90_pkg::CFG_W-1:0] height_ff, height_in;
   logic                       alpha_en_ff, alpha_en_in;
   logic                       rotate_ccw_ff, rotate_ccw_in;

   logic [CMP_W-1:0]  width_wide, height_wide;
   logic [SIDE_W-1:0] side_w, side_h;
   logic [AREA_W-1:0] area;
   logic [LOAD_W-1:0] total_ff;

   logic                     q_valid;
   logic                     q_pop;
   ir90_pkg::queue_item_type q_item;

   assign csr_ready = 1'b1;

   // Register writes.
   always_comb begin
      width_in      = width_ff;
      height_in     = height_ff;
      alpha_en_in   = alpha_en_ff;
      rotate_ccw_in = rotate_ccw_ff;
      if (csr_valid) begin
         case (csr_index)
            ir90_pkg::CSR_SOURCE_WIDTH:  width_in      = csr_data;
            ir90_pkg::CSR_SOURCE_HEIGHT: height_in     = csr_data;
            ir90_pkg::CSR_ALPHA_EN:      alpha_en_in   = csr_data[0];
            ir90_pkg::CSR_ROTATE_CCW:    rotate_ccw_in = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= ir90_pkg::CFG_SIDE_RESET;
         height_ff     <= ir90_pkg::CFG_SIDE_RESET;
         alpha_en_ff   <= 1'b0;
         rotate_ccw_ff <= 1'b1;
      end else begin
         width_ff      <= width_in;
         height_ff     <= height_in;
         alpha_en_ff   <= alpha_en_in;
         rotate_ccw_ff <= rotate_ccw_in;
      end
   end

   // Clamp each side into one to the largest supported side.
   assign width_wide  = CMP_W'(width_ff);
   assign height_wide = CMP_W'(height_ff);

   always_comb begin
      if (width_wide == '0) begin
         side_w = SIDE_W'(1);
      end else if (width_wide > CMP_W'(MAX_SIDE)) begin
         side_w = SIDE_W'(MAX_SIDE);
      end else begin
         side_w = SIDE_W'(width_wide);
      end
      if (height_wide == '0) begin
         side_h = SIDE_W'(1);
      end else if (height_wide > CMP_W'(MAX_SIDE)) begin
         side_h = SIDE_W'(MAX_SIDE);
      end else begin
         side_h = SIDE_W'(height_wide);
      end
   end

   // Pixel count of the image, registered after the multiply.
   assign area = AREA_W'(side_w) * AREA_W'(side_h);

   always_ff @(posedge clock) begin
      total_ff <= area[LOAD_W-1:0];
   end

   ir90_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   ir90_back #(
      .MAX_SIDE (MAX_SIDE)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .side_w     (side_w),
      .side_h     (side_h),
      .total      (total_ff),
      .alpha_en   (alpha_en_ff),
      .rotate_ccw (rotate_ccw_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
